// File: design/mpbc_pkg.sv
`default_nettype none

package mpbc_pkg;

  localparam logic [2:0] MODE_PASS  = 3'd0;
  localparam logic [2:0] MODE_ONOFF = 3'd1;
  localparam logic [2:0] MODE_BANG  = 3'd2;
  localparam logic [2:0] MODE_HYST  = 3'd3;
  localparam logic [2:0] MODE_PROP  = 3'd4;
  localparam logic [2:0] MODE_PID   = 3'd5;

  localparam int INDEX_W = 3;
  localparam int CFG_W   = 16;

  localparam logic [INDEX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [INDEX_W-1:0] REG_BANG   = 3'd1;
  localparam logic [INDEX_W-1:0] REG_HYST   = 3'd2;
  localparam logic [INDEX_W-1:0] REG_PGAIN  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_K0     = 3'd4;
  localparam logic [INDEX_W-1:0] REG_K1     = 3'd5;
  localparam logic [INDEX_W-1:0] REG_K2     = 3'd6;
  localparam logic [INDEX_W-1:0] REG_LIMIT  = 3'd7;

  localparam logic [14:0] LIMIT_RESET = 15'h7FFF;

  typedef struct packed {
    logic        [2:0]  mode;
    logic        [14:0] bang_level;
    logic        [15:0] hyst_width;
    logic signed [15:0] prop_gain;
    logic signed [15:0] k0;
    logic signed [15:0] k1;
    logic signed [15:0] k2;
    logic        [14:0] limit;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] reference;
    logic signed [16:0] err;
    logic signed [32:0] p0;
    logic signed [32:0] p1;
    logic signed [32:0] p2;
  } stage_t;

endpackage

`default_nettype wire

// File: design/mpbc_in_if.sv
`default_nettype none

interface mpbc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] reference;
  logic signed [15:0] measurement;

  modport source (output valid, output kind, output reference, output measurement,
                  input ready);
  modport sink   (input valid, input kind, input reference, input measurement,
                  output ready);
endinterface

`default_nettype wire

// File: design/mpbc_out_if.sv
`default_nettype none

interface mpbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               was_clamped;

  modport source (output valid, output drive, output was_clamped, input ready);
  modport sink   (input valid, input drive, input was_clamped, output ready);
endinterface

`default_nettype wire

// File: design/multimode_pid_bang_controller_core.sv
// Pipeline: a beat accepted passes the input register, product register and result register
//   in that order before it is offered on the output.
// Throughput: one beat per cycle unless stalled; the PID loop closes in the result stage.
// The input side keeps accepting while a result waits, until all three stages are full.
// Reset: synchronous, active low; clears pipeline valids, stored errors and stored output,
//   and returns the registers to their reset values (limit 32767, others 0).
`default_nettype none

module multimode_pid_bang_controller_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mpbc_in_if.sink                            in_bus,
  mpbc_out_if.source                         out_bus,
  input  wire logic                          cfg_we,
  input  wire logic [mpbc_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [mpbc_pkg::CFG_W-1:0]    cfg_wdata
);

  mpbc_pkg::cfg_t   cfg;
  mpbc_pkg::stage_t s1;
  logic             s1_valid;
  logic             down_ready;

  mpbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mpbc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg        (cfg),
    .down_ready (down_ready),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  mpbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .down_ready (down_ready),
    .out_bus    (out_bus)
  );

  a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> ($signed(out_bus.drive) <= $signed({1'b0, cfg.limit}) &&
                       $signed(out_bus.drive) >= -$signed({1'b0, cfg.limit})))
    else $error("drive beat outside limit");

  a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.was_clamped) |->
      ($signed(out_bus.drive) == $signed({1'b0, cfg.limit}) ||
       $signed(out_bus.drive) == -$signed({1'b0, cfg.limit})))
    else $error("clamped beat not at limit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (s1_valid && out_bus.valid && !out_bus.ready))
    else $error("input stalled with room in pipeline");

endmodule

`default_nettype wire

// File: design/mpbc_cfg.sv
`default_nettype none

module mpbc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mpbc_pkg::INDEX_W-1:0]  cfg_index,
  input  wire logic [mpbc_pkg::CFG_W-1:0]    cfg_wdata,
  output mpbc_pkg::cfg_t                     cfg
);

  mpbc_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        mpbc_pkg::REG_MODE:  cfg_nxt.mode       = cfg_wdata[2:0];
        mpbc_pkg::REG_BANG:  cfg_nxt.bang_level = cfg_wdata[14:0];
        mpbc_pkg::REG_HYST:  cfg_nxt.hyst_width = cfg_wdata;
        mpbc_pkg::REG_PGAIN: cfg_nxt.prop_gain  = signed'(cfg_wdata);
        mpbc_pkg::REG_K0:    cfg_nxt.k0         = signed'(cfg_wdata);
        mpbc_pkg::REG_K1:    cfg_nxt.k1         = signed'(cfg_wdata);
        mpbc_pkg::REG_K2:    cfg_nxt.k2         = signed'(cfg_wdata);
        mpbc_pkg::REG_LIMIT: cfg_nxt.limit      = cfg_wdata[14:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mpbc_pkg::MODE_PASS, 15'd0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                 mpbc_pkg::LIMIT_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/mpbc_front.sv
`default_nettype none

module mpbc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  mpbc_in_if.sink              in_bus,
  input  wire mpbc_pkg::cfg_t  cfg,
  input  wire logic            down_ready,
  output logic                 s1_valid,
  output mpbc_pkg::stage_t     s1
);

  logic               s0_valid_r, s0_valid_nxt;
  logic               s0_kind_r;
  logic signed [15:0] s0_ref_r;
  logic signed [15:0] s0_meas_r;
  logic               s1_valid_r, s1_valid_nxt;
  mpbc_pkg::stage_t   s1_r, s1_nxt;
  logic signed [16:0] last_err_r, last_err_nxt;
  logic signed [16:0] older_err_r, older_err_nxt;

  logic               s1_ready;
  logic               s0_ready;
  logic               s0_load;
  logic               s1_load;
  logic signed [16:0] err;
  logic signed [15:0] coef_a;

  assign s1_ready     = !s1_valid_r || down_ready;
  assign s0_ready     = !s0_valid_r || s1_ready;
  assign in_bus.ready = s0_ready;
  assign s0_load      = in_bus.valid && s0_ready;
  assign s1_load      = s0_valid_r && s1_ready;

  assign err    = 17'(s0_ref_r) - 17'(s0_meas_r);
  assign coef_a = (cfg.mode == mpbc_pkg::MODE_PROP) ? cfg.prop_gain : cfg.k0;

  always_comb begin
    s0_valid_nxt = s0_load || (s0_valid_r && !s1_ready);
    s1_valid_nxt = s1_load || (s1_valid_r && !down_ready);

    s1_nxt           = s1_r;
    last_err_nxt     = last_err_r;
    older_err_nxt    = older_err_r;
    if (s1_load) begin
      s1_nxt.kind      = s0_kind_r;
      s1_nxt.reference = s0_ref_r;
      s1_nxt.err       = err;
      s1_nxt.p0        = 33'(coef_a) * 33'(err);
      s1_nxt.p1        = 33'(cfg.k1) * 33'(last_err_r);
      s1_nxt.p2        = 33'(cfg.k2) * 33'(older_err_r);
      if (s0_kind_r) begin
        last_err_nxt  = '0;
        older_err_nxt = '0;
      end else if (cfg.mode == mpbc_pkg::MODE_PID) begin
        older_err_nxt = last_err_r;
        last_err_nxt  = err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      last_err_r  <= '0;
      older_err_r <= '0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      last_err_r  <= last_err_nxt;
      older_err_r <= older_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_kind_r <= in_bus.kind;
      s0_ref_r  <= in_bus.reference;
      s0_meas_r <= in_bus.measurement;
    end
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

`default_nettype wire

// File: design/mpbc_back.sv
`default_nettype none

module mpbc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mpbc_pkg::cfg_t    cfg,
  input  wire logic              s1_valid,
  input  wire mpbc_pkg::stage_t  s1,
  output logic                   down_ready,
  mpbc_out_if.source             out_bus
);

  logic               out_valid_r, out_valid_nxt;
  logic signed [15:0] drive_r, drive_nxt;
  logic               clamped_r, clamped_nxt;
  logic signed [31:0] last_out_r, last_out_nxt;

  logic               take;
  logic signed [34:0] acc;
  logic signed [34:0] rnd_src;
  logic signed [35:0] rnd_sum;
  logic signed [27:0] rnd;
  logic signed [33:0] pid_sum;
  logic signed [31:0] pid_sat;
  logic signed [18:0] err2;
  logic signed [18:0] hw;
  logic signed [31:0] bang;
  logic signed [31:0] lim;
  logic               err_pos;
  logic               err_neg;
  logic signed [31:0] u;

  assign down_ready = !out_valid_r || out_bus.ready;
  assign take       = s1_valid && down_ready;

  assign acc     = 35'(s1.p0) + 35'(s1.p1) + 35'(s1.p2);
  assign rnd_src = (cfg.mode == mpbc_pkg::MODE_PID) ? acc : 35'(s1.p0);
  assign rnd_sum = 36'(rnd_src) + 36'sd128;
  assign rnd     = signed'(rnd_sum[35:8]);
  assign pid_sum = 34'(last_out_r) + 34'(rnd);

  always_comb begin
    if (pid_sum[33:31] == 3'b000 || pid_sum[33:31] == 3'b111) begin
      pid_sat = signed'(pid_sum[31:0]);
    end else if (pid_sum[33]) begin
      pid_sat = 32'sh8000_0000;
    end else begin
      pid_sat = 32'sh7FFF_FFFF;
    end
  end

  assign err2    = {s1.err[16], s1.err, 1'b0};
  assign hw      = signed'({3'b000, cfg.hyst_width});
  assign bang    = signed'({17'd0, cfg.bang_level});
  assign lim     = signed'({17'd0, cfg.limit});
  assign err_pos = !s1.err[16] && (s1.err != '0);
  assign err_neg = s1.err[16];

  always_comb begin
    unique case (cfg.mode)
      mpbc_pkg::MODE_ONOFF: u = err_pos ? bang : '0;
      mpbc_pkg::MODE_BANG:  u = err_pos ? bang : (err_neg ? -bang : '0);
      mpbc_pkg::MODE_HYST: begin
        if (err2 > hw) begin
          u = bang;
        end else if (err2 < -hw) begin
          u = -bang;
        end else begin
          u = last_out_r;
        end
      end
      mpbc_pkg::MODE_PROP:  u = 32'(rnd);
      mpbc_pkg::MODE_PID:   u = pid_sat;
      default:              u = 32'(s1.reference);
    endcase
  end

  always_comb begin
    out_valid_nxt = take || (out_valid_r && !out_bus.ready);
    drive_nxt     = drive_r;
    clamped_nxt   = clamped_r;
    last_out_nxt  = last_out_r;
    if (take) begin
      if (s1.kind) begin
        drive_nxt    = '0;
        clamped_nxt  = 1'b0;
        last_out_nxt = '0;
      end else begin
        priority if (u > lim) begin
          drive_nxt   = lim[15:0];
          clamped_nxt = 1'b1;
        end else if (u < -lim) begin
          drive_nxt   = 16'(-lim);
          clamped_nxt = 1'b1;
        end else begin
          drive_nxt   = u[15:0];
          clamped_nxt = 1'b0;
        end
        if (cfg.mode == mpbc_pkg::MODE_HYST || cfg.mode == mpbc_pkg::MODE_PID) begin
          last_out_nxt = u;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_out_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      last_out_r  <= last_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drive_r   <= drive_nxt;
    clamped_r <= clamped_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.drive       = drive_r;
  assign out_bus.was_clamped = clamped_r;

endmodule

`default_nettype wire
